// ----- rtl/core/frl_pkg.sv -----
// Package for the fixed-point line rasterizer: payload structs, display
// limits, divider sizing and the divider request and status structs. No dependencies.
package frl_pkg;

   localparam int DISP_WIDTH  = 128;
   localparam int DISP_HEIGHT = 64;
   localparam int COORD_BITS  = 8;
   localparam int FRAC_BITS   = 8;
   localparam int ACC_BITS    = 18;
   localparam int SLOPE_BITS  = 10;

   // slope magnitude = (num << 8) / den with num <= den: nine quotient bits
   localparam int DIV_STEPS    = FRAC_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic       MODE_START = 1'b0;
   localparam logic       MODE_STEP  = 1'b1;
   localparam logic [7:0] HALF_UNIT  = 8'h80;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [1:0]            pixel_op;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [1:0]            point_op;
      logic                  visible;
      logic                  last;
   } rsp_payload_type;

   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] num;
      logic [COORD_BITS-1:0] den;
      logic                  neg;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [SLOPE_BITS-1:0] slope;
   } div_sts_type;

endpackage

// ----- rtl/core/frl_div.sv -----
// Slope divider: restoring division, one quotient bit per cycle.
// Depends on frl_pkg.
module frl_div import frl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COORD_BITS:0]     rem_ff, rem_in;
   logic [COORD_BITS-1:0]   quo_ff, quo_in;
   logic [COORD_BITS-1:0]   den_ff, den_in;
   logic                    neg_ff, neg_in;

   logic                  ge;
   logic [COORD_BITS-1:0] diff;
   logic [COORD_BITS:0]   quo_next;
   logic [COORD_BITS:0]   mag;
   logic                  final_step;

   always_comb begin
      ge         = rem_ff >= {1'b0, den_ff};
      // remainder stays below den, so eight bits hold it
      diff       = ge ? COORD_BITS'(rem_ff - {1'b0, den_ff}) : rem_ff[COORD_BITS-1:0];
      quo_next   = {quo_ff, ge};
      final_step = busy_ff && (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));
      // zero major span gives a zero slope
      mag        = (den_ff == '0) ? '0 : quo_next;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, div_req.num};
         quo_in  = '0;
         den_in  = div_req.den;
         neg_in  = div_req.neg;
      end else if (busy_ff) begin
         rem_in = {diff, 1'b0};
         quo_in = quo_next[COORD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (final_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      div_sts.busy  = busy_ff;
      div_sts.done  = final_step;
      div_sts.slope = neg_ff ? (SLOPE_BITS'(0) - {1'b0, mag}) : {1'b0, mag};
   end

endmodule

// ----- rtl/core/fixed_point_line_rasterizer.sv -----
// Top level of the fixed-point line rasterizer: line setup, walk registers,
// result register. Depends on frl_pkg and frl_div.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data): a transaction with
//    mode = start latches two endpoints and a pixel op and yields no result;
//    a transaction with mode = step yields one point while a line is active,
//    nothing otherwise.
//  - Response channel (rsp_valid / rsp_stall / rsp_data): one point per step,
//    with visible = 0 for points off the display and last = 1 on the final
//    point, after which the line is closed.
//  - Timing: a step's point sits in the response register in the cycle after
//    the step is accepted. Steps run at one per cycle while the receiver does not stall.
//  - A start holds req_stall high after acceptance while the divider works
//    out the slope one quotient bit a cycle; the first step is accepted
//    only once the divider has finished.
//  - A start during an active line drops the old line.
//  - When the receiver stalls, the point is held and req_stall follows, so
//    no step can be taken until the held point leaves.
//  - Synchronous reset closes any line, drops a pending point and aborts
//    a division in progress.
module fixed_point_line_rasterizer import frl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // line state
   logic                  line_active_ff, line_active_in;
   logic                  major_is_y_ff, major_is_y_in;
   logic                  walk_down_ff, walk_down_in;
   logic [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0] major_stop_ff, major_stop_in;
   logic [ACC_BITS-1:0]   minor_accum_ff, minor_accum_in;
   logic [SLOPE_BITS-1:0] slope_step_ff, slope_step_in;
   logic [1:0]            held_op_ff, held_op_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_sts_type div_sts;

   logic                  req_fire, start_fire, step_fire;
   logic [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  y_major;
   logic [COORD_BITS-1:0] minor;
   logic [COORD_BITS-1:0] px, py;
   logic                  is_last;
   logic [ACC_BITS-1:0]   slope_ext;

   frl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // busy divider or held point blocks new transactions
   assign req_stall  = div_sts.busy | (rsp_valid_ff & rsp_stall);
   assign req_fire   = req_valid & ~req_stall;
   assign start_fire = req_fire & (req_data.mode == MODE_START);
   assign step_fire  = req_fire & (req_data.mode == MODE_STEP) & line_active_ff;

   // line setup: spans, major axis pick, divider request
   always_comb begin
      dx  = {1'b0, req_data.x_end} - {1'b0, req_data.x_start};
      dy  = {1'b0, req_data.y_end} - {1'b0, req_data.y_start};
      adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      y_major = ady > adx;

      div_req.start = start_fire;
      div_req.num   = y_major ? adx : ady;
      div_req.den   = y_major ? ady : adx;
      div_req.neg   = dx[COORD_BITS] ^ dy[COORD_BITS];
   end

   // point of the current walk position
   always_comb begin
      minor     = minor_accum_ff[FRAC_BITS +: COORD_BITS];
      px        = major_is_y_ff ? minor : major_pos_ff;
      py        = major_is_y_ff ? major_pos_ff : minor;
      is_last   = major_pos_ff == major_stop_ff;
      slope_ext = {{(ACC_BITS - SLOPE_BITS){slope_step_ff[SLOPE_BITS-1]}}, slope_step_ff};
   end

   always_comb begin
      line_active_in = line_active_ff;
      major_is_y_in  = major_is_y_ff;
      walk_down_in   = walk_down_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      minor_accum_in = minor_accum_ff;
      slope_step_in  = slope_step_ff;
      held_op_in     = held_op_ff;

      if (start_fire) begin
         line_active_in = 1'b1;
         major_is_y_in  = y_major;
         held_op_in     = req_data.pixel_op;
         if (y_major) begin
            major_pos_in   = req_data.y_start;
            major_stop_in  = req_data.y_end;
            walk_down_in   = req_data.y_end <= req_data.y_start;
            minor_accum_in = {2'b00, req_data.x_start, HALF_UNIT};
         end else begin
            major_pos_in   = req_data.x_start;
            major_stop_in  = req_data.x_end;
            walk_down_in   = req_data.x_end <= req_data.x_start;
            minor_accum_in = {2'b00, req_data.y_start, HALF_UNIT};
         end
      end else if (step_fire) begin
         if (is_last) begin
            line_active_in = 1'b0;
         end else if (walk_down_ff) begin
            major_pos_in   = major_pos_ff - 1'b1;
            minor_accum_in = minor_accum_ff - slope_ext;
         end else begin
            major_pos_in   = major_pos_ff + 1'b1;
            minor_accum_in = minor_accum_ff + slope_ext;
         end
      end

      // slope lands when the divider finishes; no step can precede it
      if (div_sts.done) begin
         slope_step_in = div_sts.slope;
      end
   end

   // response register: load on step, hold while stalled
   always_comb begin
      rsp_valid_in = (rsp_valid_ff & rsp_stall) | step_fire;
      rsp_data_in  = rsp_data_ff;
      if (step_fire) begin
         rsp_data_in.point_x  = px;
         rsp_data_in.point_y  = py;
         rsp_data_in.point_op = held_op_ff;
         rsp_data_in.visible  = ({1'b0, px} < (COORD_BITS + 1)'(DISP_WIDTH)) &&
                                ({1'b0, py} < (COORD_BITS + 1)'(DISP_HEIGHT));
         rsp_data_in.last     = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         major_is_y_ff  <= 1'b0;
         walk_down_ff   <= 1'b0;
         major_pos_ff   <= '0;
         major_stop_ff  <= '0;
         minor_accum_ff <= '0;
         slope_step_ff  <= '0;
         held_op_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         major_is_y_ff  <= major_is_y_in;
         walk_down_ff   <= walk_down_in;
         major_pos_ff   <= major_pos_in;
         major_stop_ff  <= major_stop_in;
         minor_accum_ff <= minor_accum_in;
         slope_step_ff  <= slope_step_in;
         held_op_ff     <= held_op_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/frl_checker.sv -----
// Port-level assertions for the line rasterizer, bound to the top level.
// Depends on frl_pkg and fixed_point_line_rasterizer.
module frl_checker import frl_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // held point does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a new point only follows an accepted step
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && req_data.mode == MODE_STEP))
      else $error("response without a step transaction");

   // start occupies the divider on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_START |=> req_stall)
      else $error("request not stalled during slope division");

   // a visible point lies within the display bounds
   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.visible |->
         ({1'b0, rsp_data.point_x} < (COORD_BITS + 1)'(DISP_WIDTH)) &&
         ({1'b0, rsp_data.point_y} < (COORD_BITS + 1)'(DISP_HEIGHT)))
      else $error("visible point outside the display");

endmodule

bind fixed_point_line_rasterizer frl_checker u_frl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
